// ===== hw/rtl/ardc_pkg.sv =====
// Shared types and codes for the access range dependence checker.
package ardc_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CHECK = 2'd1,
    OP_CLEAR = 2'd2
  } ardc_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } ardc_state_e;

  // table control sent from the controller to every cell
  typedef struct packed {
    logic shift;
    logic clear;
  } ardc_ctl_t;

endpackage

// ===== hw/rtl/ardc_cell.sv =====
// One table cell: holds a stored access and passes entries and probes to its neighbor.
module ardc_cell #(
  parameter int ADDR_BITS = 48,
  parameter int END_W     = 49
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ardc_pkg::ardc_ctl_t  ctl_i,
  input  logic                 ent_valid_i,
  input  logic [ADDR_BITS-1:0] ent_addr_i,
  input  logic [END_W-1:0]     ent_end_i,
  input  logic                 ent_wr_i,
  output logic                 ent_valid_o,
  output logic [ADDR_BITS-1:0] ent_addr_o,
  output logic [END_W-1:0]     ent_end_o,
  output logic                 ent_wr_o,
  input  logic                 prb_valid_i,
  input  logic [ADDR_BITS-1:0] prb_addr_i,
  input  logic [END_W-1:0]     prb_end_i,
  input  logic                 prb_wr_i,
  input  logic                 prb_hit_i,
  output logic                 prb_valid_o,
  output logic [ADDR_BITS-1:0] prb_addr_o,
  output logic [END_W-1:0]     prb_end_o,
  output logic                 prb_wr_o,
  output logic                 prb_hit_o
);

  logic                 valid_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [END_W-1:0]     end_q;
  logic                 wr_q;
  logic                 prb_valid_q;
  logic [ADDR_BITS-1:0] prb_addr_q;
  logic [END_W-1:0]     prb_end_q;
  logic                 prb_wr_q;
  logic                 prb_hit_q;
  logic                 prb_hit_d;
  logic                 e_in_p;
  logic                 p_in_e;

  // half-open overlap, ends are one bit wider so they never wrap
  always_comb begin
    e_in_p    = (addr_q >= prb_addr_i) && (END_W'(addr_q) < prb_end_i);
    p_in_e    = (prb_addr_i >= addr_q) && (END_W'(prb_addr_i) < end_q);
    prb_hit_d = prb_hit_i | (valid_q & (wr_q | prb_wr_i) & (e_in_p | p_in_e));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      prb_valid_q <= 1'b0;
    end else begin
      prb_valid_q <= prb_valid_i;
      if (ctl_i.clear) begin
        valid_q <= 1'b0;
      end else if (ctl_i.shift) begin
        valid_q <= ent_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      addr_q <= ent_addr_i;
      end_q  <= ent_end_i;
      wr_q   <= ent_wr_i;
    end
    prb_addr_q <= prb_addr_i;
    prb_end_q  <= prb_end_i;
    prb_wr_q   <= prb_wr_i;
    prb_hit_q  <= prb_hit_d;
  end

  assign ent_valid_o = valid_q;
  assign ent_addr_o  = addr_q;
  assign ent_end_o   = end_q;
  assign ent_wr_o    = wr_q;
  assign prb_valid_o = prb_valid_q;
  assign prb_addr_o  = prb_addr_q;
  assign prb_end_o   = prb_end_q;
  assign prb_wr_o    = prb_wr_q;
  assign prb_hit_o   = prb_hit_q;

endmodule

// ===== hw/rtl/ardc_ctrl.sv =====
// Sequencer: opcode decode, entry count, sticky conflict and the output register.
module ardc_ctrl #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_valid_i,
  input  logic [1:0]                         s_op_i,
  input  logic                               s_last_i,
  output logic                               s_ready_o,
  output ardc_pkg::ardc_ctl_t                ctl_o,
  output logic                               launch_o,
  input  logic                               exit_valid_i,
  input  logic                               exit_hit_i,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic                               m_hit_o,
  output logic                               m_any_o,
  output logic                               m_full_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   m_count_o
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  ardc_pkg::ardc_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic             sticky_q;
  logic             last_q;
  logic             res_hit_q;
  logic             res_any_q;
  logic             res_full_q;
  logic             m_valid_q;
  logic             m_hit_q;
  logic             m_any_q;
  logic             m_full_q;
  logic [CNT_W-1:0] m_count_q;
  logic             accept;
  logic             is_full;
  logic             load;

  assign is_full = (cnt_q == CNT_W'(TABLE_DEPTH));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ardc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (s_op_i == ardc_pkg::OP_CHECK) ? ardc_pkg::ST_WALK : ardc_pkg::ST_HOLD;
        end
      end
      ardc_pkg::ST_WALK: begin
        if (exit_valid_i) begin
          state_d = ardc_pkg::ST_HOLD;
        end
      end
      ardc_pkg::ST_HOLD: begin
        if (load) begin
          state_d = ardc_pkg::ST_IDLE;
        end
      end
      default: state_d = ardc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o   = (state_q == ardc_pkg::ST_IDLE);
    accept      = s_valid_i & s_ready_o;
    load        = (state_q == ardc_pkg::ST_HOLD) & (~m_valid_q | m_ready_i);
    ctl_o.shift = accept & (s_op_i == ardc_pkg::OP_ADD) & ~is_full;
    ctl_o.clear = accept & (s_op_i == ardc_pkg::OP_CLEAR);
    launch_o    = accept & (s_op_i == ardc_pkg::OP_CHECK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ardc_pkg::ST_IDLE;
      cnt_q     <= '0;
      sticky_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl_o.clear) begin
        cnt_q <= '0;
      end else if (ctl_o.shift) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (state_q == ardc_pkg::ST_WALK && exit_valid_i) begin
        sticky_q <= ~last_q & (sticky_q | exit_hit_i);
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q     <= s_last_i;
      res_hit_q  <= 1'b0;
      res_any_q  <= sticky_q;
      res_full_q <= (s_op_i == ardc_pkg::OP_ADD) & is_full;
    end else if (state_q == ardc_pkg::ST_WALK && exit_valid_i) begin
      res_hit_q <= exit_hit_i;
      res_any_q <= sticky_q | exit_hit_i;
    end
    if (load) begin
      m_hit_q   <= res_hit_q;
      m_any_q   <= res_any_q;
      m_full_q  <= res_full_q;
      m_count_q <= cnt_q;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_hit_o   = m_hit_q;
  assign m_any_o   = m_any_q;
  assign m_full_o  = m_full_q;
  assign m_count_o = m_count_q;

  a_exit_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_valid_i |-> state_q == ardc_pkg::ST_WALK)
    else $error("probe left the chain outside a check");

  a_add_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.shift |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("stored add did not bump the entry count");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.clear |=> cnt_q == '0)
    else $error("clear left entries in the table");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_full |-> !ctl_o.shift)
    else $error("add stored into a full table");

endmodule

// ===== hw/rtl/access_range_dependence_checker_top.sv =====
// Top level of the access range dependence checker: cell chain and sequencer.
// Stores up to TABLE_DEPTH accesses (start, byte size, write mark) of one
// iteration and checks accesses of another iteration against them; two accesses
// conflict when their half-open byte ranges overlap and at least one writes.
// One item is worked on at a time. Add, clear and unused opcodes go from acceptance
// to the HOLD state and load their result once the output register is free. A
// check walks its probe down the chain of cells, one cell per clock, and its result
// is taken from the chain's exit and loaded into the output register the same way.
// A new item is taken as soon as the previous result sits in the output register.
module access_range_dependence_checker_top #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 48,
  parameter int SIZE_BITS   = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // access_address, access_size
  input  logic [((ADDR_BITS+SIZE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // opcode[1:0], is_write
  input  logic [2:0]               s_axis_tuser,
  input  logic                     s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // hit, any_conflict, table_full, entry_count
  output logic [((3+$clog2(TABLE_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_W = ((3 + CNT_W + 7) / 8) * 8;
  localparam int END_W = ((ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS) + 1;

  ardc_pkg::ardc_ctl_t  ctl;
  logic                 launch;
  logic [ADDR_BITS-1:0] in_addr;
  logic [SIZE_BITS-1:0] in_size;
  logic [END_W-1:0]     in_end;
  logic                 in_wr;
  logic                 m_hit;
  logic                 m_any;
  logic                 m_full;
  logic [CNT_W-1:0]     m_count;

  logic                 ent_valid [TABLE_DEPTH+1];
  logic [ADDR_BITS-1:0] ent_addr  [TABLE_DEPTH+1];
  logic [END_W-1:0]     ent_end   [TABLE_DEPTH+1];
  logic                 ent_wr    [TABLE_DEPTH+1];
  logic                 prb_valid [TABLE_DEPTH+1];
  logic [ADDR_BITS-1:0] prb_addr  [TABLE_DEPTH+1];
  logic [END_W-1:0]     prb_end   [TABLE_DEPTH+1];
  logic                 prb_wr    [TABLE_DEPTH+1];
  logic                 prb_hit   [TABLE_DEPTH+1];

  assign in_addr = s_axis_tdata[ADDR_BITS-1:0];
  assign in_size = s_axis_tdata[ADDR_BITS+SIZE_BITS-1:ADDR_BITS];
  assign in_wr   = s_axis_tuser[2];
  assign in_end  = END_W'(in_addr) + END_W'(in_size);

  assign ent_valid[0] = 1'b1;
  assign ent_addr[0]  = in_addr;
  assign ent_end[0]   = in_end;
  assign ent_wr[0]    = in_wr;
  assign prb_valid[0] = launch;
  assign prb_addr[0]  = in_addr;
  assign prb_end[0]   = in_end;
  assign prb_wr[0]    = in_wr;
  assign prb_hit[0]   = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ardc_cell #(
      .ADDR_BITS (ADDR_BITS),
      .END_W     (END_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .ent_valid_i (ent_valid[i]),
      .ent_addr_i  (ent_addr[i]),
      .ent_end_i   (ent_end[i]),
      .ent_wr_i    (ent_wr[i]),
      .ent_valid_o (ent_valid[i+1]),
      .ent_addr_o  (ent_addr[i+1]),
      .ent_end_o   (ent_end[i+1]),
      .ent_wr_o    (ent_wr[i+1]),
      .prb_valid_i (prb_valid[i]),
      .prb_addr_i  (prb_addr[i]),
      .prb_end_i   (prb_end[i]),
      .prb_wr_i    (prb_wr[i]),
      .prb_hit_i   (prb_hit[i]),
      .prb_valid_o (prb_valid[i+1]),
      .prb_addr_o  (prb_addr[i+1]),
      .prb_end_o   (prb_end[i+1]),
      .prb_wr_o    (prb_wr[i+1]),
      .prb_hit_o   (prb_hit[i+1])
    );
  end

  ardc_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_op_i       (s_axis_tuser[1:0]),
    .s_last_i     (s_axis_tlast),
    .s_ready_o    (s_axis_tready),
    .ctl_o        (ctl),
    .launch_o     (launch),
    .exit_valid_i (prb_valid[TABLE_DEPTH]),
    .exit_hit_i   (prb_hit[TABLE_DEPTH]),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_hit_o      (m_hit),
    .m_any_o      (m_any),
    .m_full_o     (m_full),
    .m_count_o    (m_count)
  );

  assign m_axis_tdata = OUT_W'({m_count, m_full, m_any, m_hit});

endmodule

// ===== test/access_range_dependence_checker_top_test.sv =====
// Stream-level testbench for the access range dependence checker top level.
module access_range_dependence_checker_top_test;

  localparam int DEPTH = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 400;

  typedef struct {
    logic [1:0]  op;
    logic [47:0] addr;
    logic [15:0] size;
    logic        wr;
    logic        last;
  } access_item_t;

  typedef struct packed {
    logic [4:0] entry_count;
    logic       table_full;
    logic       any_conflict;
    logic       hit;
  } verdict_t;

  typedef struct {
    logic [47:0] addr;
    logic [15:0] size;
    logic        wr;
  } stored_access_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  access_item_t   pending_items[$];
  verdict_t       expected_verdicts[$];
  stored_access_t shadow_table[DEPTH];
  int             shadow_count = 0;
  logic           shadow_sticky = 1'b0;

  logic in_fire = 1'b0;
  int   cyc = 0;
  int   failures = 0;
  int   n_add = 0, n_check = 0, n_clear = 0, n_unused = 0;
  int   n_rejected = 0, n_hits = 0, n_results = 0;

  access_range_dependence_checker_top #(
    .TABLE_DEPTH(DEPTH),
    .ADDR_BITS  (48),
    .SIZE_BITS  (16)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // half-open ranges, ends one bit wider than the address
  function automatic logic ranges_overlap(logic [47:0] s1, logic [15:0] z1,
                                          logic [47:0] s2, logic [15:0] z2);
    logic [48:0] e1, e2;
    e1 = {1'b0, s1} + {33'd0, z1};
    e2 = {1'b0, s2} + {33'd0, z2};
    return (s1 >= s2 && {1'b0, s1} < e2) || (s2 >= s1 && {1'b0, s2} < e1);
  endfunction

  task automatic predict_dependence(input access_item_t it);
    verdict_t v;
    v = '0;
    v.any_conflict = shadow_sticky;
    case (it.op)
      ardc_pkg::OP_ADD: begin
        n_add++;
        if (shadow_count >= DEPTH) begin
          v.table_full = 1'b1;
          n_rejected++;
        end else begin
          shadow_table[shadow_count] = '{it.addr, it.size, it.wr};
          shadow_count++;
        end
      end
      ardc_pkg::OP_CHECK: begin
        n_check++;
        for (int i = 0; i < shadow_count; i++) begin
          if ((shadow_table[i].wr || it.wr) &&
              ranges_overlap(shadow_table[i].addr, shadow_table[i].size, it.addr, it.size))
            v.hit = 1'b1;
        end
        if (v.hit) n_hits++;
        v.any_conflict = shadow_sticky | v.hit;
        shadow_sticky = it.last ? 1'b0 : v.any_conflict;
      end
      ardc_pkg::OP_CLEAR: begin
        n_clear++;
        shadow_count = 0;
      end
      default: n_unused++;
    endcase
    v.entry_count = 5'(shadow_count);
    expected_verdicts = {expected_verdicts, v};
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic push_item(input logic [1:0] op, input logic [47:0] addr,
                           input logic [15:0] size, input logic wr, input logic last);
    access_item_t it;
    it = '{op, addr, size, wr, last};
    pending_items = {pending_items, it};
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [47:0] random_addr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  function automatic logic [15:0] random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 16'd0;
    if (pick < 15) return 16'hFFFF;
    if (pick < 27) return 16'($urandom());
    return 16'($urandom_range(1, 64));
  endfunction

  function automatic logic [47:0] cluster_base();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 48'd0;
    if (pick == 1) return 48'hFFFF_FFFF_FF00;
    return random_addr();
  endfunction

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // driver: inputs move on the falling edge
  always @(negedge clk_i) begin
    logic may_idle;
    may_idle = !(cyc >= 1500 && cyc < 3000);
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (in_fire) begin
        predict_dependence(pending_items[0]);
        void'(pending_items.pop_front());
      end
      if (s_axis_tvalid && !in_fire) begin
        // hold the offered item
      end else if (pending_items.size() != 0 &&
                   !(may_idle && $urandom_range(0, 99) < 26)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pending_items[0].size, pending_items[0].addr};
        s_axis_tuser  <= {pending_items[0].wr, pending_items[0].op};
        s_axis_tlast  <= pending_items[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= !(may_idle && $urandom_range(0, 99) < 26);
    end
  end

  // monitor: results sampled on the rising edge
  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = verdict_t'(m_axis_tdata);
      n_results++;
      if (expected_verdicts.size() == 0) begin
        note_failure($sformatf("unexpected result hit=%0b any=%0b full=%0b count=%0d",
                               got.hit, got.any_conflict, got.table_full, got.entry_count));
      end else begin
        want = expected_verdicts.pop_front();
        if (got.hit !== want.hit || got.any_conflict !== want.any_conflict ||
            got.table_full !== want.table_full || got.entry_count !== want.entry_count)
          note_failure($sformatf(
            "result %0d exp hit=%0b any=%0b full=%0b count=%0d got %0b %0b %0b %0d",
            n_results, want.hit, want.any_conflict, want.table_full, want.entry_count,
            got.hit, got.any_conflict, got.table_full, got.entry_count));
      end
    end
  end

  initial begin
    int queued, pick, n;
    logic [47:0] base;
    logic fill_next;
    repeat (10) @(posedge clk_i);
    rst_ni = 1'b1;

    // directed
    push_item(ardc_pkg::OP_CHECK, 48'h0, 16'h10, 1'b1, 1'b1);              // empty table
    push_item(ardc_pkg::OP_ADD, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 1'b0); // end past the top
    push_item(ardc_pkg::OP_ADD, 48'h0, 16'h0, 1'b0, 1'b0);                 // zero size read
    push_item(ardc_pkg::OP_ADD, 48'h1000, 16'h10, 1'b1, 1'b0);
    push_item(ardc_pkg::OP_CHECK, 48'hFFFF_FFFF_FFFF, 16'h0, 1'b0, 1'b0);  // point at the top
    push_item(ardc_pkg::OP_CHECK, 48'h0, 16'h1, 1'b0, 1'b0);               // read against read
    push_item(ardc_pkg::OP_CHECK, 48'h0, 16'h0, 1'b1, 1'b0);               // two empty accesses
    push_item(ardc_pkg::OP_CHECK, 48'h0, 16'h4, 1'b1, 1'b0);               // equal starts
    push_item(ardc_pkg::OP_CHECK, 48'h100F, 16'h1, 1'b0, 1'b1);            // last byte, marked end
    push_item(ardc_pkg::OP_CHECK, 48'h1010, 16'h8, 1'b0, 1'b0);            // just past the end
    push_item(ardc_pkg::OP_CHECK, 48'h0FF8, 16'h8, 1'b1, 1'b1);            // just before the start
    push_item(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
    push_item(ardc_pkg::OP_ADD, 48'h2000, 16'h8, 1'b0, 1'b1);              // last ignored on add
    push_item(ardc_pkg::OP_CLEAR, 48'h0, 16'h0, 1'b1, 1'b1);
    push_item(ardc_pkg::OP_CHECK, 48'h2000, 16'h8, 1'b1, 1'b1);            // cleared table
    wait_drained();

    // random: mostly add/check sequences on clustered addresses, some noise
    queued = 0;
    fill_next = 1'b1;
    while (queued < RANDOM_ITEMS) begin
      if (queued >= RANDOM_ITEMS / 2 && queued < RANDOM_ITEMS / 2 + 20) begin
        wait_drained();
        queued = RANDOM_ITEMS / 2 + 20;
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        base = cluster_base();
        if (fill_next || $urandom_range(0, 1) == 1) begin
          push_item(ardc_pkg::OP_CLEAR, random_addr(), random_size(),
                    1'($urandom()), 1'($urandom()));
          queued++;
        end
        n = fill_next ? DEPTH + 2 : ($urandom_range(0, 9) == 0 ? $urandom_range(14, 19)
                                                               : $urandom_range(1, 8));
        fill_next = 1'b0;
        for (int i = 0; i < n; i++) begin
          push_item(ardc_pkg::OP_ADD, base + 48'($urandom_range(0, 255)), random_size(),
                    1'($urandom()), 1'($urandom()));
          queued++;
        end
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          push_item(ardc_pkg::OP_CHECK, base + 48'($urandom_range(0, 255)), random_size(),
                    1'($urandom()), (i == n - 1) || ($urandom_range(0, 9) == 0));
          queued++;
        end
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          push_item(2'($urandom()), random_addr(), 16'($urandom()),
                    1'($urandom()), 1'($urandom()));
          queued++;
        end
      end
    end
    wait_drained();
    repeat (DEPTH * 4) @(posedge clk_i);

    $display("covered %0d adds (%0d rejected on a full table), %0d checks (%0d hits)",
             n_add, n_rejected, n_check, n_hits);
    $display("plus %0d clears and %0d unused opcodes; %0d results, %0d mismatches",
             n_clear, n_unused, n_results, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d items pending and %0d results outstanding",
             pending_items.size(), expected_verdicts.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
